### sv/vt4_pkg.sv
// Package with the shared widths, register codes and pipeline types of the vertex transform.
package vt4_pkg;

	// Vector and matrix element width, and the growth of the products and sums.
	localparam int DATA_W   = 32;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int PAIR_W   = PROD_W + 1;
	localparam int SUM_W    = PROD_W + 2;
	localparam int NUM_ROWS = 4;
	localparam int NUM_COLS = 4;

	// Configuration port geometry.
	localparam int NUM_REGS   = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;
	localparam int REG_SEL_W  = $clog2(NUM_REGS);

	// Register indexes that hold a diagonal element at reset.
	localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS01 = REG_SEL_W'(0);
	localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS01 = REG_SEL_W'(2);
	localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS23 = REG_SEL_W'(5);
	localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS23 = REG_SEL_W'(7);

	// Clamp values of a result component.
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// Load enables of the lane pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

### sv/vt4_if.sv
// Handshake interfaces of the vector, result and configuration channels.
interface vt4_vec_if;
	import vt4_pkg::*;
	logic  valid;
	logic  ready;
	elem_t vec_x;
	elem_t vec_y;
	elem_t vec_z;
	elem_t vec_w;
	modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
		input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
		output ready);
endinterface

interface vt4_res_if;
	import vt4_pkg::*;
	logic  valid;
	logic  ready;
	elem_t out_x;
	elem_t out_y;
	elem_t out_z;
	elem_t out_w;
	logic  saturated;
	modport source (output valid, output out_x, output out_y, output out_z, output out_w,
		output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
		input saturated, output ready);
endinterface

interface vt4_cfg_if;
	import vt4_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

### sv/vt4_lane.sv
// One row lane: four exact products, a pair sum stage and the full-width row sum.
module vt4_lane import vt4_pkg::*; (
	input  logic     clk,
	input  pipe_en_t en,
	input  elem_t    vec [NUM_COLS],
	input  elem_t    row [NUM_COLS],
	output sum_t     sum_s3
);

	logic signed [PROD_W-1:0] prod_s1 [NUM_COLS];
	logic signed [PAIR_W-1:0] pair_s2 [2];

	// Stage 1: one signed 32 by 32 product per column.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				prod_s1[c] <= PROD_W'(row[c]) * PROD_W'(vec[c]);
			end
		end
	end

	// Stage 2: columns 0 and 1, and columns 2 and 3, summed in pairs.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pair_s2[0] <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
			pair_s2[1] <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
		end
	end

	// Stage 3: the full row sum, wide enough that it never overflows.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		end
	end

endmodule

### sv/vt4_merge.sv
// Merge stage: scales and clamps the four row sums, folds the clamp flags, holds the result.
module vt4_merge import vt4_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s3,
	input  sum_t             sum_s3 [NUM_ROWS],
	output logic             load_rdy,
	vt4_res_if.source        res
);

	logic        valid_q;
	elem_t       comp [NUM_ROWS];
	logic [NUM_ROWS-1:0] clamp;
	elem_t       out_q [NUM_ROWS];
	logic        sat_q;

	// The output register takes a new item when it is empty or being emptied.
	assign load_rdy = !valid_q || res.ready;

	// Arithmetic shift floors the sum; anything outside 32 bits is clamped.
	always_comb begin
		sum_t                      shifted;
		logic [SUM_W-DATA_W:0]     upper;
		for (int r = 0; r < NUM_ROWS; r++) begin
			shifted = sum_s3[r] >>> FRAC_BITS;
			upper   = shifted[SUM_W-1:DATA_W-1];
			if ((&upper) || !(|upper)) begin
				comp[r]  = shifted[DATA_W-1:0];
				clamp[r] = 1'b0;
			end else begin
				comp[r]  = shifted[SUM_W-1] ? SAT_MIN : SAT_MAX;
				clamp[r] = 1'b1;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_rdy) begin
			valid_q <= valid_s3;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_rdy) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				out_q[r] <= comp[r];
			end
			sat_q <= |clamp;
		end
	end

	assign res.valid     = valid_q;
	assign res.out_x     = out_q[0];
	assign res.out_y     = out_q[1];
	assign res.out_z     = out_q[2];
	assign res.out_w     = out_q[3];
	assign res.saturated = sat_q;

endmodule

### sv/vertex_transform_4x4_top.sv
// Top level of the 4x4 matrix by vector transform with four parallel row lanes.
// Each vector passes the product, pair sum and row sum stages, then the merge register.
// Throughput: one vector per cycle unless stalled; each lane has its own multipliers.
// Pipeline stages move whenever the next one is free, so bubbles close up under a stall.
// Reset clears all valid flags and loads the identity matrix (1.0 is 1 << FRAC_BITS).
module vertex_transform_4x4_top import vt4_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	vt4_vec_if.sink   vec,
	vt4_res_if.source res,
	vt4_cfg_if.sink   cfg
);

	localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << FRAC_BITS;

	logic [CFG_DATA_W-1:0] matrix_q [NUM_REGS];
	elem_t    vec_elem [NUM_COLS];
	elem_t    row_elem [NUM_ROWS][NUM_COLS];
	sum_t     sum_s3 [NUM_ROWS];
	pipe_en_t en;
	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;
	logic     load_rdy;

	// Matrix registers; writes beyond the last register are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (REG_SEL_W'(i) inside {REG_ROW0_COLS01, REG_ROW2_COLS23}) begin
					matrix_q[REG_SEL_W'(i)] <= ONE;
				end else if (REG_SEL_W'(i) inside {REG_ROW1_COLS01, REG_ROW3_COLS23}) begin
					matrix_q[REG_SEL_W'(i)] <= ONE << DATA_W;
				end else begin
					matrix_q[REG_SEL_W'(i)] <= '0;
				end
			end
		end else if (cfg.valid && cfg.ready && (cfg.idx < CFG_IDX_W'(NUM_REGS))) begin
			matrix_q[cfg.idx[REG_SEL_W-1:0]] <= cfg.data;
		end
	end

	// Matrix elements per lane: the even column sits in the low half of a register.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
			if (c % 2 == 1) begin : g_hi
				assign row_elem[r][c] = matrix_q[r*2 + c/2][CFG_DATA_W-1:DATA_W];
			end else begin : g_lo
				assign row_elem[r][c] = matrix_q[r*2 + c/2][DATA_W-1:0];
			end
		end
	end

	assign vec_elem[0] = vec.vec_x;
	assign vec_elem[1] = vec.vec_y;
	assign vec_elem[2] = vec.vec_z;
	assign vec_elem[3] = vec.vec_w;

	// A stage loads when it is empty or the stage after it loads.
	always_comb begin
		en.s3 = !valid_s3 || load_rdy;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign vec.ready = en.s1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= vec.valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// One lane per matrix row.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
		vt4_lane u_lane (
			.clk    (clk),
			.en     (en),
			.vec    (vec_elem),
			.row    (row_elem[r]),
			.sum_s3 (sum_s3[r])
		);
	end

	vt4_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3),
		.load_rdy (load_rdy),
		.res      (res)
	);

endmodule

### sv/vt4_checker.sv
// Port-level checker of the vertex transform and its bind to the top level.
module vt4_checker import vt4_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  vec_ready,
	input logic  res_valid,
	input logic  res_ready,
	input elem_t out_x,
	input elem_t out_y,
	input elem_t out_z,
	input elem_t out_w,
	input logic  saturated,
	input logic  cfg_ready
);

	// A result that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	// The input side only stalls when every stage is full behind a held result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!vec_ready |-> res_valid && !res_ready)
		else $error("input stalled with room in the pipeline");

	// A clamp flag needs at least one component at a clamp value.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && saturated |->
			out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX || out_y == SAT_MIN ||
			out_z == SAT_MAX || out_z == SAT_MIN || out_w == SAT_MAX || out_w == SAT_MIN)
		else $error("saturated set without a clamped component");

	// Configuration writes are never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind vertex_transform_4x4_top vt4_checker u_vt4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vec_ready (vec.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.out_x     (res.out_x),
	.out_y     (res.out_y),
	.out_z     (res.out_z),
	.out_w     (res.out_w),
	.saturated (res.saturated),
	.cfg_ready (cfg.ready)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the 4x4 matrix by vector transform, with a predictor and idling.
module tb_top;
	import vt4_pkg::*;

	localparam int FRAC           = 16;
	localparam int CYCLE_LIMIT    = 100000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int NUM_PHASES     = 4;
	localparam int SETS_PER_PHASE = 3;
	localparam int VECS_PER_SET   = 120;
	localparam int REPORT_MAX     = 10;

	localparam elem_t ONE_Q = elem_t'(1) <<< FRAC;

	// Configuration register indexes as driven on the write channel.
	localparam logic [CFG_IDX_W-1:0] IDX_ROW0_COLS01 = CFG_IDX_W'(REG_ROW0_COLS01);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW0_COLS23 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW1_COLS01 = CFG_IDX_W'(REG_ROW1_COLS01);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW1_COLS23 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW2_COLS01 = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW2_COLS23 = CFG_IDX_W'(REG_ROW2_COLS23);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW3_COLS01 = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] IDX_ROW3_COLS23 = CFG_IDX_W'(REG_ROW3_COLS23);
	localparam logic [CFG_IDX_W-1:0] IDX_PAST_END    = CFG_IDX_W'(NUM_REGS);
	localparam logic [CFG_IDX_W-1:0] IDX_TOP         = '1;

	// Signed 32-bit range, seen at the width of the row sums.
	localparam sum_t SUM_HI = (sum_t'(1) <<< (DATA_W - 1)) - sum_t'(1);
	localparam sum_t SUM_LO = -(sum_t'(1) <<< (DATA_W - 1));

	typedef logic [NUM_COLS-1:0][DATA_W-1:0] vec4_t;

	typedef struct packed {
		vec4_t comp;
		logic  sat;
	} xform_res_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_VEC, ROW_VEC_TYPED} row_kind_e;
	typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EDGE} word_style_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [DATA_W-1:0]     vx, vy, vz, vw;
		logic [DATA_W-1:0]     ex, ey, ez, ew;
		logic                  esat;
	} dir_row_t;

	// Directed steps: identity after reset, clamping both ways, ignored indexes, rounding down.
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED_STEPS [DIR_ROWS] = '{
		'{ROW_VEC_TYPED, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000,
			32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW0_COLS01, 64'h7FFF_FFFF_7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b1},
		'{ROW_VEC_TYPED, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0,
			32'h8000_0000, 32'h8000_0000, 0, 0, 1'b1},
		'{ROW_WRITE, IDX_PAST_END, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_TOP, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0,
			32'h8000_0000, 32'h8000_0000, 0, 0, 1'b1},
		'{ROW_WRITE, IDX_ROW0_COLS01, 64'h0000_0000_0000_0001, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_VEC_TYPED, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0000_0001, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW0_COLS23, 64'h8000_0000_8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW1_COLS23, 64'h7FFF_FFFF_7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW2_COLS01, 64'h0001_0000_FFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW3_COLS01, 64'h0000_8000_0002_0000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_VEC, 0, 0, 32'h0001_0000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 0, 0, 0, 1'b0},
		'{ROW_VEC, 0, 0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW1_COLS01, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW2_COLS23, 64'hFFFF_FFFF_0000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_WRITE, IDX_ROW3_COLS23, 64'h8000_0000_8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ROW_VEC, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			0, 0, 0, 0, 1'b0},
		'{ROW_VEC, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			0, 0, 0, 0, 1'b0}
	};

	logic clk;
	logic arst_n;

	vt4_vec_if vec_ch ();
	vt4_res_if res_ch ();
	vt4_cfg_if cfg_ch ();

	vertex_transform_4x4_top #(
		.FRAC_BITS(FRAC)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.vec   (vec_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// Shadow matrix, expected transforms and run bookkeeping.
	logic [CFG_DATA_W-1:0] mat_regs [NUM_REGS];
	xform_res_t            xform_q [$];
	xform_res_t            typed_exp;
	bit                    typed_now;
	int                    idle_pct;
	int                    stall_pct;
	int                    bad_results;
	int                    res_seen;
	int                    cycles;

	// Row r of the shadow matrix dotted with the vector, scaled down and clamped.
	function automatic xform_res_t transform_vec(input vec4_t v);
		xform_res_t               r;
		logic [CFG_DATA_W-1:0]    pair;
		elem_t                    coef;
		logic signed [PROD_W-1:0] prod;
		sum_t                     acc;
		sum_t                     scaled;
		r.sat = 1'b0;
		for (int row = 0; row < NUM_ROWS; row++) begin
			acc = '0;
			for (int col = 0; col < NUM_COLS; col++) begin
				pair = mat_regs[row * 2 + col / 2];
				coef = (col % 2) ? pair[CFG_DATA_W-1:DATA_W] : pair[DATA_W-1:0];
				prod = coef * elem_t'(v[col]);
				acc = acc + prod;
			end
			// Arithmetic shift rounds toward minus infinity.
			scaled = acc >>> FRAC;
			if (scaled > SUM_HI) begin
				r.comp[row] = SAT_MAX;
				r.sat = 1'b1;
			end else if (scaled < SUM_LO) begin
				r.comp[row] = SAT_MIN;
				r.sat = 1'b1;
			end else begin
				r.comp[row] = scaled[DATA_W-1:0];
			end
		end
		return r;
	endfunction

	// One 32-bit word drawn mostly in the given style, sometimes in any other.
	function automatic elem_t pick_word(input word_style_e bias);
		word_style_e st;
		st = ($urandom_range(0, 3) == 0) ? word_style_e'($urandom_range(0, 2)) : bias;
		case (st)
			STYLE_SMALL: begin
				return elem_t'(int'($urandom_range(0, 2**18 - 1)) - 2**17);
			end
			STYLE_EDGE: begin
				case ($urandom_range(0, 6))
					0: return SAT_MAX;
					1: return SAT_MIN;
					2: return elem_t'(0);
					3: return ONE_Q;
					4: return -ONE_Q;
					5: return elem_t'(1);
					default: return '1;
				endcase
			end
			default: begin
				return elem_t'($urandom);
			end
		endcase
	endfunction

	task automatic report_bad(input string what, input xform_res_t want, input xform_res_t got);
		bad_results++;
		if (bad_results <= REPORT_MAX) begin
			$display("result %0d %s: expected x=%h y=%h z=%h w=%h sat=%b", res_seen, what,
				want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.sat);
			$display("    got x=%h y=%h z=%h w=%h sat=%b",
				got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
		end
	endtask

	// Drop valid and wait until every expected transform has come out.
	task automatic wait_drained();
		vec_ch.valid = 1'b0;
		while (xform_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.idx   = idx;
		cfg_ch.data  = data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Offer one vector after a random gap; valid stays high for a following item.
	task automatic send_vec(input vec4_t v, input bit typed, input xform_res_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			vec_ch.valid = 1'b0;
			@(negedge clk);
		end
		vec_ch.valid = 1'b1;
		vec_ch.vec_x = v[0];
		vec_ch.vec_y = v[1];
		vec_ch.vec_z = v[2];
		vec_ch.vec_w = v[3];
		typed_now    = typed;
		typed_exp    = want;
		@(posedge clk);
		while (!vec_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls.
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Track register writes, predict each accepted vector and check each accepted result.
	always @(posedge clk) begin
		xform_res_t got;
		xform_res_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready && cfg_ch.idx < NUM_REGS) begin
				mat_regs[cfg_ch.idx[REG_SEL_W-1:0]] = cfg_ch.data;
			end
			if (vec_ch.valid && vec_ch.ready) begin
				xform_q.push_back(typed_now ? typed_exp : transform_vec({vec_ch.vec_w,
					vec_ch.vec_z, vec_ch.vec_y, vec_ch.vec_x}));
			end
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.out_w, res_ch.out_z, res_ch.out_y, res_ch.out_x, res_ch.saturated};
				if (xform_q.size() == 0) begin
					report_bad("arrived with nothing pending", '0, got);
				end else begin
					want = xform_q.pop_front();
					if (got.comp !== want.comp || got.sat !== want.sat) begin
						report_bad("differs", want, got);
					end
				end
				res_seen++;
			end
		end
	end

	// Stimulus: reset, the directed steps, then random matrices under each idling pattern.
	initial begin
		dir_row_t              step;
		vec4_t                 v;
		elem_t                 lo;
		elem_t                 hi;
		int                    k;
		int                    mkind;
		word_style_e           vstyle;
		vec_ch.valid = 1'b0;
		vec_ch.vec_x = '0;
		vec_ch.vec_y = '0;
		vec_ch.vec_z = '0;
		vec_ch.vec_w = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx   = '0;
		cfg_ch.data  = '0;
		typed_now    = 1'b0;
		typed_exp    = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		bad_results  = 0;
		res_seen     = 0;
		cycles       = 0;
		arst_n       = 1'b0;

		// The matrix comes out of reset as identity.
		for (int i = 0; i < NUM_REGS; i++) mat_regs[i] = '0;
		mat_regs[REG_ROW0_COLS01] = {elem_t'(0), ONE_Q};
		mat_regs[REG_ROW1_COLS01] = {ONE_Q, elem_t'(0)};
		mat_regs[REG_ROW2_COLS23] = {elem_t'(0), ONE_Q};
		mat_regs[REG_ROW3_COLS23] = {ONE_Q, elem_t'(0)};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed steps; a write always waits for the pipeline to empty.
		for (int i = 0; i < DIR_ROWS; i++) begin
			step = DIRECTED_STEPS[i];
			if (step.kind == ROW_WRITE) begin
				wait_drained();
				write_reg(step.idx, step.data);
			end else begin
				send_vec({step.vw, step.vz, step.vy, step.vx}, step.kind == ROW_VEC_TYPED,
					{step.ew, step.ez, step.ey, step.ex, step.esat});
			end
		end

		// Random part: each idling pattern runs over several matrices.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int s = 0; s < SETS_PER_PHASE; s++) begin
				wait_drained();
				case (ph)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 54; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 54; end
					default: begin idle_pct = 15; stall_pct = 15; end
				endcase

				// Matrix kinds rotate: full range, small, edge values, all one clamp value.
				k = ph * SETS_PER_PHASE + s;
				mkind = k % 4;
				for (int i = 0; i < NUM_REGS; i++) begin
					if (mkind == 3) begin
						lo = ((k / 4) % 2) ? SAT_MIN : SAT_MAX;
						hi = lo;
					end else begin
						lo = pick_word(word_style_e'(mkind));
						hi = pick_word(word_style_e'(mkind));
					end
					write_reg(CFG_IDX_W'(i), {hi, lo});
				end
				if ($urandom_range(0, 1)) begin
					write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), {$urandom, $urandom});
				end

				// Vectors lean toward small values so that many results stay in range.
				for (int n = 0; n < VECS_PER_SET; n++) begin
					vstyle = $urandom_range(0, 1) ? STYLE_SMALL
						: word_style_e'($urandom_range(0, 2));
					for (int c = 0; c < NUM_COLS; c++) v[c] = pick_word(vstyle);
					send_vec(v, 1'b0, '0);
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (bad_results == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### filelist.f
sv/vt4_pkg.sv
sv/vt4_if.sv
sv/vt4_lane.sv
sv/vt4_merge.sv
sv/vertex_transform_4x4_top.sv
sv/vt4_checker.sv
bench/tb_top.sv
